[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; the including scope provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, disabled in reset
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define SPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/sps_pkg.sv]
// Shared constants for the shuffled playlist sequencer.
// No dependencies.
package sps_pkg;
  localparam int MAX_ITEMS_DEF = 1024;
  localparam logic [31:0] SEED_RESET = 32'd2463534242;
  localparam int FUNC_W = 2;
  localparam int NCOUNT_W = 11;
  localparam int ITEM_W = 10;
  localparam int DRAW_BITS = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_RELOAD  = 2'd0,
    FN_ADVANCE = 2'd1,
    FN_BACK    = 2'd2,
    FN_JUMP    = 2'd3
  } func_t;
endpackage

[hdl/shuffled_playlist_sequencer_core.sv]
// Advance or back moves the position and reads the items back; jump searches the
// order for the target; reload or an end-of-pass advance refills, then shuffles it.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// The order lives in one RAM (one write, one read port, registered read data); draws use
// a bit-serial remainder unit on 32-bit draws. Reset clears control and loads the
// generator with the reset seed; the order RAM is not cleared.
module shuffled_playlist_sequencer_core
  import sps_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                random_seed_wr,
  input  logic [31:0]         random_seed,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [NCOUNT_W-1:0] new_count,
  input  logic [ITEM_W-1:0]   target_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ITEM_W-1:0]   current_item,
  output logic [ITEM_W-1:0]   play_position,
  output logic [NCOUNT_W-1:0] item_count,
  output logic                is_empty,
  output logic [ITEM_W-1:0]   next_item,
  output logic                next_known,
  output logic                jump_found
);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int BW = $clog2(DRAW_BITS);

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_FILL    = 17'b00000000000000010,
    S_DRAW    = 17'b00000000000000100,
    S_SW_A    = 17'b00000000000001000,
    S_SW_B    = 17'b00000000000010000,
    S_SW_W1   = 17'b00000000000100000,
    S_SW_W2   = 17'b00000000001000000,
    S_AV_RD   = 17'b00000000010000000,
    S_AV_CHK  = 17'b00000000100000000,
    S_LAST_RD = 17'b00000001000000000,
    S_LAST_W  = 17'b00000010000000000,
    S_SR_RD   = 17'b00000100000000000,
    S_SR_CMP  = 17'b00001000000000000,
    S_CUR_RD  = 17'b00010000000000000,
    S_CUR_W   = 17'b00100000000000000,
    S_NXT_W   = 17'b01000000000000000,
    S_DONE    = 17'b10000000000000000
  } state_t;

  state_t state, post_st;

  logic [IW-1:0] play_order [MAX_ITEMS];
  logic [IW-1:0] rd_addr, wr_addr, wr_data, rd_data;
  logic          wr_en;

  logic [CW-1:0]       count, idx, bound, rem, rem_next, pos1;
  logic [CW:0]         rem_sh;
  logic [IW-1:0]       pos, swap_a, swap_b, tmp, last, w_cur, w_nxt;
  logic [ITEM_W-1:0]   target;
  logic [31:0]         rng, xs, dvd;
  logic [BW-1:0]       bcnt;
  logic                w_known, found, avoid_req, avoid_phase, can_load;
  logic [CW-1:0]       ncnt;

  always_comb begin
    xs = rng ^ (rng << 13);
    xs = xs ^ (xs >> 17);
    xs = xs ^ (xs << 5);
  end

  assign rem_sh   = {rem, dvd[31]};
  assign rem_next = (rem_sh >= {1'b0, bound}) ? CW'(rem_sh - {1'b0, bound}) : CW'(rem_sh);
  assign pos1     = CW'(pos) + CW'(1);
  assign ncnt     = (32'(new_count) > 32'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(new_count);
  assign post_st  = (avoid_req && count > CW'(1)) ? S_AV_RD : S_CUR_RD;
  assign in_stall = (state != S_IDLE);
  assign can_load = !out_valid || !out_stall;

  always_comb begin
    rd_addr = pos;
    wr_en   = 1'b0;
    wr_addr = IW'(idx);
    wr_data = IW'(idx);
    unique case (state)
      S_FILL:   wr_en = 1'b1;
      S_SW_A:   rd_addr = swap_a;
      S_SW_B:   rd_addr = swap_b;
      S_SW_W1: begin
        wr_en   = 1'b1;
        wr_addr = swap_a;
        wr_data = rd_data;
      end
      S_SW_W2: begin
        wr_en   = 1'b1;
        wr_addr = swap_b;
        wr_data = tmp;
      end
      S_AV_RD:  rd_addr = '0;
      S_SR_RD:  rd_addr = IW'(idx);
      S_CUR_W:  rd_addr = IW'(pos1);
      default:  rd_addr = pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) play_order[wr_addr] <= wr_data;
    rd_data <= play_order[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      pos         <= '0;
      rng         <= SEED_RESET;
      out_valid   <= 1'b0;
      found       <= 1'b0;
      avoid_req   <= 1'b0;
      avoid_phase <= 1'b0;
    end else begin
      if (random_seed_wr) rng <= random_seed;
      if (state == S_DONE && can_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            found       <= 1'b0;
            avoid_req   <= 1'b0;
            avoid_phase <= 1'b0;
            target      <= target_item;
            state       <= S_CUR_RD;
            unique case (func_t'(func))
              FN_RELOAD: begin
                count <= ncnt;
                pos   <= '0;
                idx   <= '0;
                if (ncnt != '0) state <= S_FILL;
              end
              FN_ADVANCE: begin
                if (count != '0) begin
                  if (pos1 < count) pos <= IW'(pos1);
                  else state <= S_LAST_RD;
                end
              end
              FN_BACK: begin
                if (count != '0) pos <= (pos == '0) ? IW'(count - CW'(1)) : pos - IW'(1);
              end
              FN_JUMP: begin
                idx <= '0;
                if (count != '0) state <= S_SR_RD;
              end
            endcase
          end
        end
        S_LAST_RD: state <= S_LAST_W;
        S_LAST_W: begin
          last      <= rd_data;
          pos       <= '0;
          idx       <= '0;
          avoid_req <= 1'b1;
          state     <= S_FILL;
        end
        S_FILL: begin
          if (idx == count - CW'(1)) begin
            if (count > CW'(1)) begin
              idx   <= count;
              bound <= count;
              rng   <= xs;
              dvd   <= xs;
              rem   <= '0;
              bcnt  <= '0;
              state <= S_DRAW;
            end else begin
              state <= post_st;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DRAW: begin
          rem  <= rem_next;
          dvd  <= dvd << 1;
          bcnt <= bcnt + BW'(1);
          if (bcnt == BW'(DRAW_BITS - 1)) begin
            if (avoid_phase) begin
              swap_a <= '0;
              swap_b <= IW'(rem_next + CW'(1));
            end else begin
              swap_a <= IW'(idx - CW'(1));
              swap_b <= IW'(rem_next);
            end
            state <= S_SW_A;
          end
        end
        S_SW_A:  state <= S_SW_B;
        S_SW_B: begin
          tmp   <= rd_data;
          state <= S_SW_W1;
        end
        S_SW_W1: state <= S_SW_W2;
        S_SW_W2: begin
          if (avoid_phase) begin
            state <= S_CUR_RD;
          end else if (idx - CW'(1) > CW'(1)) begin
            idx   <= idx - CW'(1);
            bound <= idx - CW'(1);
            rng   <= xs;
            dvd   <= xs;
            rem   <= '0;
            bcnt  <= '0;
            state <= S_DRAW;
          end else begin
            state <= post_st;
          end
        end
        S_AV_RD: state <= S_AV_CHK;
        S_AV_CHK: begin
          if (rd_data == last) begin
            avoid_phase <= 1'b1;
            bound       <= count - CW'(1);
            rng         <= xs;
            dvd         <= xs;
            rem         <= '0;
            bcnt        <= '0;
            state       <= S_DRAW;
          end else begin
            state <= S_CUR_RD;
          end
        end
        S_SR_RD: state <= S_SR_CMP;
        S_SR_CMP: begin
          if (32'(rd_data) == 32'(target)) begin
            pos   <= IW'(idx);
            found <= 1'b1;
            state <= S_CUR_RD;
          end else if (idx + CW'(1) == count) begin
            state <= S_CUR_RD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SR_RD;
          end
        end
        S_CUR_RD: begin
          w_cur   <= '0;
          w_nxt   <= '0;
          w_known <= 1'b0;
          state   <= (count == '0) ? S_DONE : S_CUR_W;
        end
        S_CUR_W: begin
          w_cur <= rd_data;
          state <= (pos1 < count) ? S_NXT_W : S_DONE;
        end
        S_NXT_W: begin
          w_nxt   <= rd_data;
          w_known <= 1'b1;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (can_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && can_load) begin
      current_item  <= ITEM_W'(w_cur);
      play_position <= ITEM_W'(pos);
      item_count    <= NCOUNT_W'(count);
      is_empty      <= (count == '0);
      next_item     <= ITEM_W'(w_nxt);
      next_known    <= w_known;
      jump_found    <= found;
    end
  end
endmodule

[hdl/sps_checker.sv]
// Port-level checks for the shuffled playlist sequencer core, bound to the core module.
// Depends on sps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sps_checker
  import sps_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ITEM_W-1:0]   current_item,
  input logic [ITEM_W-1:0]   play_position,
  input logic [NCOUNT_W-1:0] item_count,
  input logic                is_empty,
  input logic                next_known
);
  `SPS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SPS_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (item_count == '0), "empty flag mismatch")
  `SPS_ASSERT_NOW(a_empty_zero, out_valid && is_empty, !next_known && current_item == '0 && play_position == '0, "empty result not zero")
  `SPS_ASSERT_NOW(a_next_range, out_valid && next_known, ({1'b0, play_position} + 1'b1) < item_count, "next flagged at last position")
endmodule

bind shuffled_playlist_sequencer_core sps_checker u_sps_checker (.*);
